// ===== hw/rtl/flsh64_pkg.sv =====
// Shared types, constants and helpers for the four-lane stream hash.
package flsh64_pkg;

    typedef logic [63:0] word_t;

    localparam word_t PRIME_A = 64'h9e3779b185ebca87;
    localparam word_t PRIME_B = 64'hc2b2ae3d27d4eb4f;
    localparam word_t PRIME_C = 64'h165667b19e3779f9;
    localparam word_t PRIME_D = 64'h85ebca77c2b2ae63;
    localparam word_t PRIME_E = 64'h9fb21c651e98df25;
    localparam word_t FIN_M1  = 64'hff51afd7ed558ccd;
    localparam word_t FIN_M2  = 64'hc4ceb9fe1a85ec53;

    localparam logic [3:0] FULL_WORD_BYTES = 4'd8;
    localparam logic [1:0] BUF_FULL        = 2'd3;
    localparam logic [1:0] LAST_LANE       = 2'd3;
    localparam logic [1:0] MUL_LAST_STEP   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_COMBINE,
        ST_MIXW,
        ST_MIXB,
        ST_FIN1,
        ST_FIN2,
        ST_EMIT
    } state_t;

    function automatic word_t rotl64(input word_t v, input int unsigned r);
        return (v << r) | (v >> (64 - r));
    endfunction

endpackage

// ===== hw/rtl/flsh64_msg_if.sv =====
// Message word channel: one 64-bit word per beat.
interface flsh64_msg_if;
    logic        valid;
    logic        ready;
    logic [63:0] word_data;
    logic [3:0]  byte_count;
    logic        last_item;
    logic [31:0] message_length;

    modport source (
        output valid, word_data, byte_count, last_item, message_length,
        input  ready
    );
    modport sink (
        input  valid, word_data, byte_count, last_item, message_length,
        output ready
    );
endinterface

// ===== hw/rtl/flsh64_hash_if.sv =====
// Hash result channel: one hash beat per message.
interface flsh64_hash_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;
    logic        length_error;

    modport source (
        output valid, hash_value, length_error,
        input  ready
    );
    modport sink (
        input  valid, hash_value, length_error,
        output ready
    );
endinterface

// ===== hw/rtl/four_lane_stream_hash64_top.sv =====
// Four-lane streaming 64-bit message hash, top level.
//
// msg carries a message as big-endian 64-bit words, one per beat; the first
// beat of a message also brings its total length, which seeds four lanes.
// hash returns one beat per message, after the beat with last_item set.
// All multiplications go through one 32x32 multiplier; a 64-bit product is
// summed from low x low, high x low and low x high partial products in turn.
// Non-last words that do not complete a four-word block are taken back to back.
// A block-completing word keeps msg.ready low while the four lanes are folded.
// The last beat gives the hash after an optional block fold, the lane combine,
// one mix per leftover word or tail byte, the finaliser and the output load.
// The result waits in an output register, so a stalled receiver blocks msg
// only once the next message's hash is ready to load.
// Reset clears all control state and drops hash.valid; msg.ready is high
// from reset onwards, as the sequencer starts idle.
module four_lane_stream_hash64_top
    import flsh64_pkg::*;
#(
    parameter int LENGTH_WIDTH = 32
)(
    input  logic          clk,
    input  logic          rst_n,
    flsh64_msg_if.sink    msg,
    flsh64_hash_if.source hash
);

    localparam word_t LEN_MASK64 = {64{1'b1}} >> (64 - LENGTH_WIDTH);
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

    state_t                  state_reg, state_next;
    logic [1:0]              step_reg, step_next;
    logic [1:0]              idx_reg, idx_next;
    logic [2:0]              byte_reg, byte_next;
    logic [3:0]              cnt_reg, cnt_next;
    logic                    last_reg, last_next;
    logic [1:0]              bufc_reg, bufc_next;
    logic [LENGTH_WIDTH-1:0] seen_reg, seen_next;
    logic [LENGTH_WIDTH-1:0] exp_reg, exp_next;
    logic                    in_msg_reg, in_msg_next;
    logic                    fault_reg, fault_next;
    logic                    out_valid_reg, out_valid_next;

    word_t word_reg, word_next;
    word_t acc_reg, acc_next;
    word_t h_reg, h_next;
    word_t lane_reg [4];
    word_t lane_next [4];
    word_t out_hash_reg, out_hash_next;
    logic  out_err_reg, out_err_next;
    word_t wbuf_reg [3];
    logic  wbuf_we;

    logic                    acc_in;
    logic [3:0]              cnt_eff;
    logic                    over8;
    logic [1:0]              bufc_base;
    logic [LENGTH_WIDTH-1:0] seen_base;
    logic                    fault_base;
    logic                    short_word;
    logic                    fold_now;
    logic [LENGTH_WIDTH:0]   sum_ext;
    word_t                   len64;

    logic        mul_busy, mul_done;
    word_t       mul_x, mul_c, mul_res, mix_w, prod;
    logic [31:0] mul_a, mul_b;

    assign msg.ready        = (state_reg == ST_IDLE);
    assign hash.valid       = out_valid_reg;
    assign hash.hash_value  = out_hash_reg;
    assign hash.length_error = out_err_reg;

    assign acc_in     = msg.valid && msg.ready;
    assign over8      = msg.byte_count > FULL_WORD_BYTES;
    assign cnt_eff    = over8 ? FULL_WORD_BYTES : msg.byte_count;
    assign bufc_base  = in_msg_reg ? bufc_reg : 2'd0;
    assign seen_base  = in_msg_reg ? seen_reg : '0;
    assign fault_base = in_msg_reg && fault_reg;
    assign short_word = !msg.last_item && (cnt_eff != FULL_WORD_BYTES);
    assign fold_now   = (bufc_base == BUF_FULL) && (cnt_eff == FULL_WORD_BYTES);
    assign sum_ext    = {1'b0, seen_base} + (LENGTH_WIDTH+1)'(cnt_eff);
    assign len64      = {32'd0, msg.message_length} & LEN_MASK64;

    // shared multiplier: operand and constant picked by the sequencer
    always_comb
    begin
        case (idx_reg)
            2'd0:    mix_w = wbuf_reg[0];
            2'd1:    mix_w = wbuf_reg[1];
            2'd2:    mix_w = wbuf_reg[2];
            default: mix_w = word_reg;
        endcase
        if (idx_reg == bufc_reg)
        begin
            mix_w = word_reg;
        end

        mul_x = '0;
        mul_c = '0;
        case (state_reg)
            ST_FOLD:
            begin
                case (idx_reg)
                    2'd0:
                    begin
                        mul_x = rotl64(lane_reg[0] ^ wbuf_reg[0], 29);
                        mul_c = PRIME_E;
                    end
                    2'd1:
                    begin
                        mul_x = rotl64(lane_reg[1] ^ wbuf_reg[1], 31);
                        mul_c = PRIME_A;
                    end
                    2'd2:
                    begin
                        mul_x = rotl64(lane_reg[2] ^ wbuf_reg[2], 33);
                        mul_c = PRIME_B;
                    end
                    default:
                    begin
                        mul_x = rotl64(lane_reg[3] ^ word_reg, 35);
                        mul_c = PRIME_C;
                    end
                endcase
            end
            ST_MIXW:
            begin
                mul_x = rotl64(h_reg ^ mix_w, 27);
                mul_c = PRIME_E;
            end
            ST_MIXB:
            begin
                mul_x = rotl64(h_reg ^ {56'd0, word_reg[63:56]}, 11);
                mul_c = PRIME_A;
            end
            ST_FIN1:
            begin
                mul_x = h_reg ^ (h_reg >> 33);
                mul_c = FIN_M1;
            end
            ST_FIN2:
            begin
                mul_x = h_reg ^ (h_reg >> 29);
                mul_c = FIN_M2;
            end
            default:
            begin
                mul_x = '0;
                mul_c = '0;
            end
        endcase
    end

    assign mul_busy = state_reg inside {ST_FOLD, ST_MIXW, ST_MIXB, ST_FIN1, ST_FIN2};
    assign mul_done = mul_busy && (step_reg == MUL_LAST_STEP);
    assign mul_a    = (step_reg == 2'd1) ? mul_x[63:32] : mul_x[31:0];
    assign mul_b    = (step_reg == MUL_LAST_STEP) ? mul_c[63:32] : mul_c[31:0];
    assign prod     = {32'd0, mul_a} * {32'd0, mul_b};
    assign mul_res  = acc_reg + {prod[31:0], 32'd0};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc_in && !short_word)
                begin
                    if (fold_now)
                        state_next = ST_FOLD;
                    else if (msg.last_item)
                        state_next = ST_COMBINE;
                end
            end
            ST_FOLD:
            begin
                if (mul_done && (idx_reg == LAST_LANE))
                    state_next = last_reg ? ST_COMBINE : ST_IDLE;
            end
            ST_COMBINE:
            begin
                if ((bufc_reg != 2'd0) || (cnt_reg == FULL_WORD_BYTES))
                    state_next = ST_MIXW;
                else if (cnt_reg != 4'd0)
                    state_next = ST_MIXB;
                else
                    state_next = ST_FIN1;
            end
            ST_MIXW:
            begin
                if (mul_done)
                begin
                    if (idx_reg == bufc_reg)
                        state_next = ST_FIN1;
                    else if ((idx_reg + 2'd1) != bufc_reg)
                        state_next = ST_MIXW;
                    else if (cnt_reg == FULL_WORD_BYTES)
                        state_next = ST_MIXW;
                    else if (cnt_reg != 4'd0)
                        state_next = ST_MIXB;
                    else
                        state_next = ST_FIN1;
                end
            end
            ST_MIXB:
            begin
                if (mul_done && (({1'b0, byte_reg} + 4'd1) == cnt_reg))
                    state_next = ST_FIN1;
            end
            ST_FIN1:
            begin
                if (mul_done)
                    state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                if (mul_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || hash.ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        step_next      = mul_busy ? (mul_done ? 2'd0 : step_reg + 2'd1) : 2'd0;
        idx_next       = idx_reg;
        byte_next      = byte_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        bufc_next      = bufc_reg;
        seen_next      = seen_reg;
        exp_next       = exp_reg;
        in_msg_next    = in_msg_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg && !hash.ready;
        word_next      = word_reg;
        h_next         = h_reg;
        out_hash_next  = out_hash_reg;
        out_err_next   = out_err_reg;
        wbuf_we        = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            lane_next[i] = lane_reg[i];
        end

        case (step_reg)
            2'd0:    acc_next = prod;
            2'd1:    acc_next = mul_res;
            default: acc_next = acc_reg;
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if (acc_in)
                begin
                    if (!in_msg_reg)
                    begin
                        exp_next     = len64[LENGTH_WIDTH-1:0];
                        lane_next[0] = PRIME_A ^ len64;
                        lane_next[1] = PRIME_B + len64;
                        lane_next[2] = PRIME_C ^ (len64 << 1);
                        lane_next[3] = PRIME_D + (len64 << 1);
                    end
                    in_msg_next = 1'b1;
                    fault_next  = fault_base || over8;
                    seen_next   = seen_base;
                    bufc_next   = bufc_base;
                    if (short_word)
                    begin
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        if (sum_ext[LENGTH_WIDTH])
                        begin
                            seen_next  = LEN_MAX;
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            seen_next = sum_ext[LENGTH_WIDTH-1:0];
                        end
                        word_next = msg.word_data;
                        idx_next  = 2'd0;
                        byte_next = 3'd0;
                        last_next = msg.last_item;
                        cnt_next  = fold_now ? 4'd0 : cnt_eff;
                        if (!msg.last_item && !fold_now)
                        begin
                            wbuf_we   = 1'b1;
                            bufc_next = bufc_base + 2'd1;
                        end
                        if (msg.last_item)
                        begin
                            in_msg_next = 1'b0;
                        end
                    end
                end
            end
            ST_FOLD:
            begin
                if (mul_done)
                begin
                    lane_next[idx_reg] = mul_res;
                    idx_next           = idx_reg + 2'd1;
                    if (idx_reg == LAST_LANE)
                    begin
                        bufc_next = 2'd0;
                    end
                end
            end
            ST_COMBINE:
            begin
                h_next = lane_reg[0] ^ rotl64(lane_reg[1], 17) ^
                         rotl64(lane_reg[2], 31) ^ rotl64(lane_reg[3], 47);
                idx_next  = 2'd0;
                byte_next = 3'd0;
            end
            ST_MIXW:
            begin
                if (mul_done)
                begin
                    h_next   = mul_res;
                    idx_next = idx_reg + 2'd1;
                end
            end
            ST_MIXB:
            begin
                if (mul_done)
                begin
                    h_next    = mul_res;
                    byte_next = byte_reg + 3'd1;
                    word_next = word_reg << 8;
                end
            end
            ST_FIN1, ST_FIN2:
            begin
                if (mul_done)
                begin
                    h_next = mul_res;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || hash.ready)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = h_reg ^ (h_reg >> 32);
                    out_err_next   = fault_reg || (seen_reg != exp_reg);
                end
            end
            default:
            begin
                h_next = h_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            idx_reg       <= '0;
            byte_reg      <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            bufc_reg      <= '0;
            seen_reg      <= '0;
            exp_reg       <= '0;
            in_msg_reg    <= 1'b0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            byte_reg      <= byte_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            bufc_reg      <= bufc_next;
            seen_reg      <= seen_next;
            exp_reg       <= exp_next;
            in_msg_reg    <= in_msg_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        acc_reg      <= acc_next;
        h_reg        <= h_next;
        out_hash_reg <= out_hash_next;
        out_err_reg  <= out_err_next;
        for (int i = 0; i < 4; i++)
        begin
            lane_reg[i] <= lane_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wbuf_we)
        begin
            wbuf_reg[bufc_base] <= msg.word_data;
        end
    end

endmodule

// ===== hw/rtl/flsh64_checker.sv =====
// Port-level checks for the four-lane stream hash, bound to the top level.
module flsh64_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        msg_valid,
    input logic        msg_ready,
    input logic        msg_last,
    input logic        hash_valid,
    input logic        hash_ready,
    input logic [63:0] hash_value,
    input logic        length_error
);

    // stalled hash beat holds
    a_hash_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hash_valid && !hash_ready |=> hash_valid && $stable(hash_value) &&
            $stable(length_error))
        else $error("hash beat changed while stalled");

    // last beat starts the flush, so the next word must wait
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && msg_last |=> !msg_ready)
        else $error("msg accepted straight after a last beat");

    // a new hash is loaded only from the emit step, never while idle
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hash_valid) |-> !$past(msg_ready))
        else $error("hash appeared while the block was idle");

    // the flush runs before a hash can show
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && msg_last |=> ##1 !$rose(hash_valid))
        else $error("hash produced too soon after last beat");

endmodule

bind four_lane_stream_hash64_top flsh64_checker u_flsh64_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .msg_valid    (msg.valid),
    .msg_ready    (msg.ready),
    .msg_last     (msg.last_item),
    .hash_valid   (hash.valid),
    .hash_ready   (hash.ready),
    .hash_value   (hash.hash_value),
    .length_error (hash.length_error)
);
